// ===== rtl/core/ace_pkg.sv =====
// Package: shared types, constants and AES helper functions for the CTR seed expander.
package ace_pkg;
    localparam int KEY_WORD_W  = 64;
    localparam int LEN_W       = 32;
    localparam int COUNT_W     = 7;
    localparam int BLOCK_BYTES = 16;
    localparam int MAX_BURST_DEFAULT = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_ROUNDS  = 14;

    typedef enum logic [2:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_DIV  = 3'd4,
        REG_MLEN = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ENCRYPT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic                 restart;
        logic [COUNT_W-1:0]   count;
    } cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits at bits [127-8i -: 8]
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            b[i] = s[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r+4*c] = sbox(b[r + 4*((c + r) % 4)]);
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = t[i];
        return o;
    endfunction
endpackage

// ===== rtl/core/ace_if.sv =====
// Interfaces: valid/ready channels for requests, bytes and configuration writes.
interface ace_req_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [6:0] byte_count;
    modport source (output valid, restart, byte_count, input ready);
    modport sink   (input valid, restart, byte_count, output ready);
endinterface

interface ace_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ace_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ace_front.sv =====
// Front end: accepts requests, saturates the count, drops empty non-restart requests, 2-deep queue.
module ace_front #(
    parameter int MAX_BURST = ace_pkg::MAX_BURST_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    ace_req_if.sink        req,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output ace_pkg::cmd_t  cmd
);
    import ace_pkg::*;

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    cmd_t       in_cmd;
    logic       push, pop, keep;

    always_comb
    begin
        in_cmd.restart = req.restart;
        in_cmd.count   = (req.byte_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST)
                                                                : req.byte_count;
    end

    assign req.ready = (cnt_reg != 2'd2);
    // an empty request without restart does nothing
    assign keep      = in_cmd.restart || (in_cmd.count != '0);
    assign push      = req.valid && req.ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= in_cmd;
    end
endmodule

// ===== rtl/core/ace_back.sv =====
// Back end: counter, iterative AES-256 (one round per cycle) and byte emitter.
module ace_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ace_pkg::cmd_t                 cmd,
    input  logic [4*ace_pkg::KEY_WORD_W-1:0] key,
    input  logic [ace_pkg::KEY_WORD_W-1:0]   diversifier,
    input  logic [ace_pkg::LEN_W-1:0]        max_length,
    ace_out_if.source                     out
);
    import ace_pkg::*;

    back_state_t  state_reg, state_next;
    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] buf_reg;
    logic [4:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [127:0] st_reg;
    logic [255:0] rk_reg;        // {w[i..i+3] of previous, current} sliding key window
    logic [3:0]   rnd_reg;
    logic [7:0]   rcon_reg;
    logic         ov_reg;
    logic [7:0]   ob_reg;
    logic         ol_reg;
    logic         take, emit, need_block, out_free;
    logic [127:0] ctr_base, ctr_inc;
    logic [127:0] rk_new;
    logic [31:0]  w_prev, tw;
    logic [3:0]   p;

    assign out_free  = !ov_reg || out.ready;
    assign out.valid = ov_reg;
    assign out.data_byte = ob_reg;
    assign out.last_byte = ol_reg;

    assign cmd_ready = (state_reg == BK_IDLE);
    assign take      = cmd_valid && cmd_ready;

    // next 128-bit group of round key words; even rounds start a new 8-word group
    always_comb
    begin
        rk_new = '0;
        w_prev = rk_reg[31:0];
        for (int k = 0; k < 4; k++)
        begin
            if (k == 0)
            begin
                if (!rnd_reg[0])
                    tw = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {rcon_reg, 24'h0};
                else
                    tw = sub_word(w_prev);
            end
            else
                tw = w_prev;
            rk_new[127-32*k -: 32] = rk_reg[255-32*k -: 32] ^ tw;
            w_prev = rk_new[127-32*k -: 32];
        end
    end

    always_comb
    begin
        ctr_base = (take && cmd.restart) ? {diversifier, max_length, 32'h0} : ctr_reg;
        ctr_inc  = ctr_base + 128'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        ctr_next   = ctr_reg;
        need_block = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    left_next = cmd.count;
                    if (cmd.restart)
                    begin
                        pos_next = 5'd16;
                        ctr_next = ctr_base;
                    end
                    if (cmd.count != '0)
                        state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (pos_reg[4])
                begin
                    need_block = 1'b1;
                    ctr_next   = ctr_inc;
                    state_next = BK_ENCRYPT;
                end
                else if (out_free)
                begin
                    emit      = 1'b1;
                    pos_next  = pos_reg + 5'd1;
                    left_next = left_reg - COUNT_W'(1);
                    if (left_reg == COUNT_W'(1))
                        state_next = BK_IDLE;
                end
            end
            BK_ENCRYPT:
            begin
                if (rnd_reg == 4'(NUM_ROUNDS))
                begin
                    pos_next   = 5'd0;
                    state_next = BK_EMIT;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign p = pos_reg[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ctr_reg   <= '0;
            pos_reg   <= 5'd16;
            left_reg  <= '0;
            ov_reg    <= 1'b0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out.ready)
                ov_reg <= 1'b0;
            if (need_block)
                rnd_reg <= 4'd1;
            else if (state_reg == BK_ENCRYPT)
                rnd_reg <= rnd_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_reg <= buf_reg[127-8*p -: 8];
            ol_reg <= (left_reg == COUNT_W'(1));
        end
        if (need_block)
        begin
            st_reg   <= ctr_inc ^ key[255:128];
            rk_reg   <= key;
            rcon_reg <= 8'h01;
        end
        else if (state_reg == BK_ENCRYPT)
        begin
            // round 1 takes the lower key half already held; later rounds expand 4 words
            if (rnd_reg == 4'd1)
                st_reg <= aes_round(st_reg, 1'b0) ^ rk_reg[127:0];
            else
            begin
                st_reg <= aes_round(st_reg, rnd_reg == 4'(NUM_ROUNDS)) ^ rk_new;
                rk_reg <= {rk_reg[127:0], rk_new};
                if (!rnd_reg[0])
                    rcon_reg <= xtime(rcon_reg);
            end
            if (rnd_reg == 4'(NUM_ROUNDS))
                buf_reg <= aes_round(st_reg, 1'b1) ^ rk_new;
        end
    end
endmodule

// ===== rtl/core/aes256_ctr_seed_expander_unit.sv =====
// Top level: AES-256 counter-mode keystream byte generator.
//  channel  dir  fields                      transfer when
//  req      in   restart, byte_count         req.valid && req.ready
//  out      out  data_byte, last_byte        out.valid && out.ready
//  cfg      in   index, data                 cfg.valid && cfg.ready (always ready)
// One byte per cycle while a block is buffered and the output is not stalled;
// each new block is loaded and then run through the 14 AES rounds, and no
// byte is emitted meanwhile. Reset clears counter, queue and control;
// the buffer starts empty. Output stalls hold the back end; the front queue
// keeps taking up to two requests meanwhile.
module aes256_ctr_seed_expander_unit #(
    parameter int MAX_BURST = ace_pkg::MAX_BURST_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    ace_req_if.sink  req,
    ace_out_if.source out,
    ace_cfg_if.sink  cfg
);
    import ace_pkg::*;

    logic [KEY_WORD_W-1:0] key_reg [4];
    logic [KEY_WORD_W-1:0] div_reg;
    logic [LEN_W-1:0]      mlen_reg;
    logic                  cmd_valid, cmd_ready;
    cmd_t                  cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            div_reg  <= '0;
            mlen_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_KEY0: key_reg[0] <= cfg.data;
                REG_KEY1: key_reg[1] <= cfg.data;
                REG_KEY2: key_reg[2] <= cfg.data;
                REG_KEY3: key_reg[3] <= cfg.data;
                REG_DIV:  div_reg    <= cfg.data;
                REG_MLEN: mlen_reg   <= cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    ace_front #(.MAX_BURST(MAX_BURST)) u_front (
        .clk, .rst_n, .req,
        .cmd_valid, .cmd_ready, .cmd
    );

    ace_back u_back (
        .clk, .rst_n,
        .cmd_valid, .cmd_ready, .cmd,
        .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .diversifier(div_reg),
        .max_length(mlen_reg),
        .out
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.data_byte))
        else $error("output changed while stalled");
    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready || cmd.count == '0 || $past(cmd.count) == '0)
        else $error("back end took a command while busy");
`endif
endmodule

// ===== tb/sv/aes256_ctr_seed_expander_unit_tb.sv =====
// Testbench: checks the AES-256 CTR keystream generator against a behavioral predictor.
module aes256_ctr_seed_expander_unit_tb;
    import ace_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    ace_req_if req ();
    ace_out_if out ();
    ace_cfg_if cfg ();

    aes256_ctr_seed_expander_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .out   (out.source),
        .cfg   (cfg.sink)
    );

    // Byte expected on the output channel.
    typedef struct {
        logic [7:0] data_byte;
        logic       last_byte;
    } ks_byte_t;

    // Stimulus row for the directed table; chk marks a hand-typed expected first byte.
    typedef struct {
        logic       restart;
        logic [6:0] byte_count;
        logic       chk;
        logic [7:0] first_byte;
    } row_t;

    // Predictor state: shadow of the configuration and the keystream engine.
    logic [63:0]  key_sh [4];
    logic [63:0]  div_sh;
    logic [31:0]  mlen_sh;
    logic [127:0] ctr_sh;
    logic [127:0] buf_sh;
    int unsigned  pos_sh;

    ks_byte_t     ks_q [$];
    int           n_err;
    int           n_bytes;
    int           n_items;
    int           idle_cnt;
    int           hold_cycles;
    bit           rx_quiet;
    logic [127:0] rk [15];

    localparam int WATCHDOG = 20000;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        n_err++;
        $display("mismatch %s: got %h want %h (byte %0d)", what, got, want, n_bytes);
    endtask

    // Table lookup written locally from the standard AES forward S-box.
    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        logic [7:0] s [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return s[a];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-256 key schedule into rk[0..14], byte 0 of each round key in the top bits.
    task automatic schedule_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = key_sh[i/2][63 - 32*(i%2) -: 32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = {sub_byte(t[23:16]) ^ rcon, sub_byte(t[15:8]), sub_byte(t[7:0]),
                     sub_byte(t[31:24])};
                rcon = gf_double(rcon);
            end
            else if (i % 8 == 4)
                t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    task automatic encrypt(input logic [127:0] pt, output logic [127:0] ct);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] st;
        schedule_keys();
        st = pt ^ rk[0];
        for (int rnd = 1; rnd <= 14; rnd++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = st[127-8*i -: 8];
            // SubBytes + ShiftRows, then MixColumns except in the final round
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r+4*c] = sub_byte(s[r + 4*((c + r) % 4)]);
            if (rnd < 14)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                st[127-8*i -: 8] = t[i];
            st = st ^ rk[rnd];
        end
        ct = st;
    endtask

    // Queue the keystream bytes one request produces.
    task automatic predict_keystream(input logic rs, input logic [6:0] cnt_in);
        int unsigned cnt;
        ks_byte_t    e;
        cnt = (cnt_in > 7'd64) ? 64 : cnt_in;
        if (rs)
        begin
            ctr_sh = {div_sh, mlen_sh, 32'h0};
            pos_sh = BLOCK_BYTES;
        end
        for (int k = 0; k < cnt; k++)
        begin
            if (pos_sh >= BLOCK_BYTES)
            begin
                ctr_sh = ctr_sh + 128'd1;     // wraps at 2^128
                encrypt(ctr_sh, buf_sh);
                pos_sh = 0;
            end
            e.data_byte = buf_sh[127 - 8*pos_sh -: 8];
            e.last_byte = (k == cnt - 1);
            ks_q.push_back(e);
            pos_sh++;
        end
    endtask

    // Configuration write; the port is always ready, but honor the handshake anyway.
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg.index = idx;
        cfg.data  = val;
        cfg.valid = 1'b1;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_sh[idx] = val;
            REG_DIV:  div_sh = val;
            REG_MLEN: mlen_sh = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_req(input logic rs, input logic [6:0] cnt);
        req.restart    = rs;
        req.byte_count = cnt;
        req.valid      = 1'b1;
        do @(posedge clk); while (!req.ready);
        predict_keystream(rs, cnt);
        n_items++;
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            g = 0;
        repeat (g) @(negedge clk);
    endtask

    // Drain: every expected byte arrived, then allow the block's latency to settle.
    task automatic drain();
        while (ks_q.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic random_config(input int mode);
        logic [63:0] v;
        for (int i = 0; i < 6; i++)
        begin
            case (mode)
                0: v = '0;
                1: v = '1;
                default: v = {$urandom(), $urandom()};
            endcase
            write_reg(cfg_reg_t'(i), v);
        end
    endtask

    // Receiver: random ready with long stretches, plus one forced long hold-off.
    initial
    begin
        int g;
        out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_quiet)
                out.ready <= 1'b1;
            else
            begin
                g = $urandom_range(0, 19);
                out.ready <= (g < 14) ? 1'b1 : 1'b0;
                if (g == 19)
                    hold_cycles = $urandom_range(10, 80);
            end
        end
    end

    // Output checker, sampling at the rising edge.
    always @(posedge clk)
    begin
        ks_byte_t e;
        if (rst_n && out.valid && out.ready)
        begin
            if (ks_q.size() == 0)
                report("unexpected byte", out.data_byte, 8'h00);
            else
            begin
                e = ks_q.pop_front();
                if (out.data_byte !== e.data_byte)
                    report("data_byte", out.data_byte, e.data_byte);
                if (out.last_byte !== e.last_byte)
                    report("last_byte", {7'b0, out.last_byte}, {7'b0, e.last_byte});
            end
            n_bytes++;
        end
    end

    // Watchdog: cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (out.valid && out.ready) || (cfg.valid && cfg.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCHDOG)
        begin
            $display("watchdog expired, %0d bytes pending", ks_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed table. First byte of the zero-key, zero-counter stream: AES-256 of counter 1
    // is worked by the predictor, so only the flags are read off here.
    row_t dir_tab [] = '{
        '{1'b0, 7'd1,   1'b0, 8'h00},  // out of reset, no restart
        '{1'b0, 7'd15,  1'b0, 8'h00},  // finish first block exactly
        '{1'b0, 7'd0,   1'b0, 8'h00},  // empty request
        '{1'b1, 7'd0,   1'b0, 8'h00},  // empty request still reloads
        '{1'b0, 7'd16,  1'b0, 8'h00},
        '{1'b1, 7'd64,  1'b0, 8'h00},  // largest burst
        '{1'b0, 7'd127, 1'b0, 8'h00},  // oversized, saturates
        '{1'b0, 7'd65,  1'b0, 8'h00},
        '{1'b1, 7'd3,   1'b0, 8'h00},
        '{1'b0, 7'd17,  1'b0, 8'h00},  // crosses a block boundary mid-buffer
        '{1'b1, 7'd33,  1'b0, 8'h00},
        '{1'b0, 7'd42,  1'b0, 8'h00},
        '{1'b0, 7'd85,  1'b0, 8'h00}
    };

    initial
    begin
        int n;
        n_err = 0; n_bytes = 0; n_items = 0; idle_cnt = 0; hold_cycles = 0;
        rx_quiet = 0;
        for (int i = 0; i < 4; i++)
            key_sh[i] = '0;
        div_sh = '0; mlen_sh = '0; ctr_sh = '0; buf_sh = '0; pos_sh = BLOCK_BYTES;
        req.valid = 1'b0; req.restart = 1'b0; req.byte_count = '0;
        cfg.valid = 1'b0; cfg.index = REG_KEY0; cfg.data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed phase with reset configuration, then all-ones registers.
        foreach (dir_tab[i])
        begin
            send_req(dir_tab[i].restart, dir_tab[i].byte_count);
            sender_gap();
        end
        drain();
        random_config(1);
        send_req(1'b1, 7'd40);
        send_req(1'b0, 7'd64);    // all-ones key and counter prefix
        drain();

        // Largest counter prefix: diversifier and length all ones.
        write_reg(REG_DIV, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MLEN, 64'hFFFF_FFFF);
        send_req(1'b1, 7'd48);
        drain();

        // Pressure: receiver holds off while the sender keeps offering.
        hold_cycles = 400;
        for (int i = 0; i < 4; i++)
            send_req(1'b0, 7'd64);
        drain();

        // Random phases, each with a new configuration written while the stream is idle.
        for (int ph = 0; ph < 6; ph++)
        begin
            random_config(ph == 5 ? 0 : 2);
            n = 73;
            for (int i = 0; i < n; i++)
            begin
                logic       rs;
                logic [6:0] cnt;
                rs = ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 9))
                    0:       cnt = $urandom_range(65, 127);
                    1:       cnt = 7'd64;
                    2:       cnt = 7'd0;
                    default: cnt = $urandom_range(1, 20);
                endcase
                send_req(rs, cnt);
                sender_gap();
            end
            // sender pauses until everything has come back
            drain();
        end

        rx_quiet = 1;
        drain();
        $display("covered %0d requests, %0d keystream bytes, 8 config settings incl. extremes",
                 n_items, n_bytes);
        $display("restart, empty, oversized, all-ones counter and output back-pressure exercised");
        if (n_err == 0 && ks_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
